[src/bpfa_pkg.sv]
// Shared types and constants for the bitmap page frame allocator.
package bpfa_pkg;

  localparam int MAX_PAGES_DEF = 65536;
  localparam int WORD_W        = 32;
  localparam int WORD_SH       = 5;
  localparam int FRAME_SH      = 12;

  localparam logic [16:0] TOTAL_RESET = 17'd65536;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_LOCK    = 3'd0;
  localparam cmd_t CMD_FREE    = 3'd1;
  localparam cmd_t CMD_RESERVE = 3'd2;
  localparam cmd_t CMD_RELEASE = 3'd3;
  localparam cmd_t CMD_REQUEST = 3'd4;
  localparam cmd_t CMD_CLEAR   = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK     = 2'd0;
  localparam status_t STAT_NOFREE = 2'd1;
  localparam status_t STAT_RANGE  = 2'd2;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_TOTAL  = 1'b0;
  localparam cfg_idx_t CFG_OFFSET = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN_RD,
    S_RUN_LOAD,
    S_RUN_BIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FINISH
  } state_t;

  // One page transition for the count unit.
  typedef struct packed {
    logic en;
    logic give;    // clear bit, page goes back to free
    logic to_res;  // reserved count instead of used count
  } cnt_op_t;

endpackage

[src/bpfa_in_if.sv]
// Command channel: valid/ready with the command payload.
interface bpfa_in_if;
  logic              valid;
  logic              ready;
  bpfa_pkg::cmd_t    cmd;
  logic [15:0]       first_page;
  logic [16:0]       page_count;

  modport source (output valid, output cmd, output first_page, output page_count,
                  input ready);
  modport sink   (input valid, input cmd, input first_page, input page_count,
                  output ready);
endinterface

[src/bpfa_out_if.sv]
// Result channel: valid/ready with the result payload.
interface bpfa_out_if;
  logic                valid;
  logic                ready;
  bpfa_pkg::status_t   status;
  logic [15:0]         frame_number;
  logic [48:0]         mapped_address;
  logic [16:0]         free_pages;
  logic [16:0]         used_pages;
  logic [16:0]         reserved_pages;

  modport source (output valid, output status, output frame_number,
                  output mapped_address, output free_pages, output used_pages,
                  output reserved_pages, input ready);
  modport sink   (input valid, input status, input frame_number,
                  input mapped_address, input free_pages, input used_pages,
                  input reserved_pages, output ready);
endinterface

[src/bpfa_bitmap.sv]
// Taken-bit memory, one word of frames per entry, registered read.
module bpfa_bitmap #(
  parameter int NW = 2048,
  parameter int AW = 11
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [bpfa_pkg::WORD_W-1:0]  rd_data,
  input  logic                         we,
  input  logic [AW-1:0]                wr_addr,
  input  logic [bpfa_pkg::WORD_W-1:0]  wr_data
);

  logic [bpfa_pkg::WORD_W-1:0] mem [NW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/bpfa_count.sv]
// Saturating page count update for one bit transition.
module bpfa_count #(
  parameter int CW = 17
) (
  input  bpfa_pkg::cnt_op_t op,
  input  logic              bit_val,
  input  logic [CW-1:0]     eff,
  input  logic [CW-1:0]     free_c,
  input  logic [CW-1:0]     used_c,
  input  logic [CW-1:0]     res_c,
  output logic              new_bit,
  output logic [CW-1:0]     free_n,
  output logic [CW-1:0]     used_n,
  output logic [CW-1:0]     res_n
);

  logic [CW-1:0] other;
  logic [CW-1:0] other_n;
  logic [CW:0]   other_inc;
  logic [CW:0]   free_inc;

  always_comb begin
    other     = op.to_res ? res_c : used_c;
    other_n   = other;
    free_n    = free_c;
    new_bit   = bit_val;
    other_inc = {1'b0, other} + (CW+1)'(1);
    free_inc  = {1'b0, free_c} + (CW+1)'(1);
    if (op.en) begin
      if (!op.give) begin
        new_bit = 1'b1;
        if (!bit_val && free_c != '0 && other_inc <= {1'b0, eff}) begin
          free_n  = free_c - CW'(1);
          other_n = CW'(other_inc);
        end
      end else begin
        new_bit = 1'b0;
        if (bit_val && other != '0 && free_inc <= {1'b0, eff}) begin
          free_n  = CW'(free_inc);
          other_n = other - CW'(1);
        end
      end
    end
    used_n = op.to_res ? used_c : other_n;
    res_n  = op.to_res ? other_n : res_c;
  end

endmodule

[src/bitmap_page_frame_allocator_unit.sv]
// Bitmap page frame allocator: one command in, one result out per command.
// Range commands walk the run one frame per cycle on a word held in a register, which is
// read (S_RUN_RD) and loaded (S_RUN_LOAD) again at each new 32-frame word.
// A request scans the bitmap one word at a time, a read (S_SCAN_RD) then a check
// (S_SCAN_CHK), up to the first free frame. Clear all, and reset, sweep all NW words of
// the bitmap memory (2048 at the default) one word per cycle, while no command is taken.
// Range and request commands share the one bitmap memory and the one count unit.
module bitmap_page_frame_allocator_unit #(
  parameter int MAX_PAGES = bpfa_pkg::MAX_PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  bpfa_in_if.sink           in_ch,
  bpfa_out_if.source        out_ch,
  input  logic              cfg_we,
  input  bpfa_pkg::cfg_idx_t cfg_index,
  input  logic [47:0]       cfg_data
);

  localparam int WW = bpfa_pkg::WORD_W;
  localparam int WS = bpfa_pkg::WORD_SH;
  localparam int NW = (MAX_PAGES + WW - 1) / WW;
  localparam int AW = $clog2(NW);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int FA = $clog2(MAX_PAGES);
  localparam int XW = (CW > 17) ? CW + 1 : 18;

  bpfa_pkg::state_t state, state_next;

  logic [16:0]            total;
  logic [47:0]            offset;
  logic [CW-1:0]          eff;
  logic [CW-1:0]          free_c, used_c, res_c;
  logic [CW-1:0]          free_next, used_next, res_next;
  logic [CW-1:0]          cur, cur_next;
  logic [CW-1:0]          end_f, end_f_next;
  logic [AW-1:0]          w, w_next;
  logic [AW-1:0]          sweep, sweep_next;
  logic [AW-1:0]          last_w;
  logic [WW-1:0]          wreg, wreg_next;
  bpfa_pkg::cmd_t         cmd_r, cmd_r_next;
  bpfa_pkg::status_t      st_r, st_r_next;
  logic [FA-1:0]          frame_r, frame_r_next;
  logic                   clr_report, clr_report_next;
  logic                   out_load;

  logic                   rd_en, we;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [WW-1:0]          rd_data, wr_data;

  bpfa_pkg::cnt_op_t      op;
  logic                   bit_val, new_bit;
  logic [CW-1:0]          free_n, used_n, res_n;

  logic [XW-1:0]          run_sum, eff_x, run_end;
  logic [31:0]            eff_m1, rem;
  logic [WW-1:0]          mask, masked, wnew;
  logic [WS-1:0]          pos;
  logic                   accept;

  assign eff = (XW'(total) > XW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(total);
  assign eff_x   = XW'(eff);
  assign run_sum = XW'(in_ch.first_page) + XW'(in_ch.page_count);
  assign run_end = (run_sum > eff_x) ? eff_x : run_sum;
  assign eff_m1  = 32'(eff) - 32'd1;
  assign last_w  = eff_m1[AW+WS-1:WS];
  assign rem     = 32'(eff) - 32'({w, {WS{1'b0}}});

  assign in_ch.ready = (state == bpfa_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  bpfa_bitmap #(.NW(NW), .AW(AW)) u_bitmap (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bpfa_count #(.CW(CW)) u_count (
    .op      (op),
    .bit_val (bit_val),
    .eff     (eff),
    .free_c  (free_c),
    .used_c  (used_c),
    .res_c   (res_c),
    .new_bit (new_bit),
    .free_n  (free_n),
    .used_n  (used_n),
    .res_n   (res_n)
  );

  // lowest free frame within the scanned word; frames past the total read as taken
  always_comb begin
    for (int j = 0; j < WW; j++) begin
      mask[j] = (32'(j) < rem);
    end
    masked = rd_data | ~mask;
    pos = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (!masked[j]) begin
        pos = WS'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpfa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    end_f_next      = end_f;
    w_next          = w;
    sweep_next      = sweep;
    wreg_next       = wreg;
    cmd_r_next      = cmd_r;
    st_r_next       = st_r;
    frame_r_next    = frame_r;
    clr_report_next = clr_report;
    free_next       = free_n;
    used_next       = used_n;
    res_next        = res_n;
    rd_en           = 1'b0;
    rd_addr         = w;
    we              = 1'b0;
    wr_addr         = cur[AW+WS-1:WS];
    wnew            = wreg;
    wr_data         = wreg;
    op              = '0;
    bit_val         = wreg[cur[WS-1:0]];
    out_load        = 1'b0;

    unique case (state)
      bpfa_pkg::S_CLEAR: begin
        we         = 1'b1;
        wr_addr    = sweep;
        wr_data    = '0;
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(NW - 1)) begin
          state_next = clr_report ? bpfa_pkg::S_FINISH : bpfa_pkg::S_IDLE;
        end
      end
      bpfa_pkg::S_IDLE: begin
        if (accept) begin
          cmd_r_next   = in_ch.cmd;
          st_r_next    = bpfa_pkg::STAT_OK;
          frame_r_next = '0;
          state_next   = bpfa_pkg::S_FINISH;
          case (in_ch.cmd) inside
            bpfa_pkg::CMD_LOCK, bpfa_pkg::CMD_FREE,
            bpfa_pkg::CMD_RESERVE, bpfa_pkg::CMD_RELEASE: begin
              if (in_ch.page_count != '0 && run_sum > eff_x) begin
                st_r_next = bpfa_pkg::STAT_RANGE;
              end
              cur_next   = CW'(in_ch.first_page);
              end_f_next = CW'(run_end);
              if (XW'(in_ch.first_page) < run_end) begin
                state_next = bpfa_pkg::S_RUN_RD;
              end
            end
            bpfa_pkg::CMD_REQUEST: begin
              w_next = '0;
              if (eff == '0) begin
                st_r_next = bpfa_pkg::STAT_NOFREE;
              end else begin
                state_next = bpfa_pkg::S_SCAN_RD;
              end
            end
            bpfa_pkg::CMD_CLEAR: begin
              free_next       = eff;
              used_next       = '0;
              res_next        = '0;
              sweep_next      = '0;
              clr_report_next = 1'b1;
              state_next      = bpfa_pkg::S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      bpfa_pkg::S_RUN_RD: begin
        rd_en      = 1'b1;
        rd_addr    = cur[AW+WS-1:WS];
        state_next = bpfa_pkg::S_RUN_LOAD;
      end
      bpfa_pkg::S_RUN_LOAD: begin
        wreg_next  = rd_data;
        state_next = bpfa_pkg::S_RUN_BIT;
      end
      bpfa_pkg::S_RUN_BIT: begin
        op.en     = 1'b1;
        op.give   = (cmd_r == bpfa_pkg::CMD_FREE) || (cmd_r == bpfa_pkg::CMD_RELEASE);
        op.to_res = (cmd_r == bpfa_pkg::CMD_RESERVE) || (cmd_r == bpfa_pkg::CMD_RELEASE);
        wnew[cur[WS-1:0]] = new_bit;
        wreg_next = wnew;
        wr_data   = wnew;
        cur_next  = cur + CW'(1);
        if (cur + CW'(1) == end_f) begin
          we         = 1'b1;
          state_next = bpfa_pkg::S_FINISH;
        end else if (cur[WS-1:0] == {WS{1'b1}}) begin
          we         = 1'b1;
          state_next = bpfa_pkg::S_RUN_RD;
        end
      end
      bpfa_pkg::S_SCAN_RD: begin
        rd_en      = 1'b1;
        state_next = bpfa_pkg::S_SCAN_CHK;
      end
      bpfa_pkg::S_SCAN_CHK: begin
        if (masked != {WW{1'b1}}) begin
          op.en        = 1'b1;
          bit_val      = 1'b0;
          we           = 1'b1;
          wr_addr      = w;
          wr_data      = rd_data | (WW'(1) << pos);
          frame_r_next = FA'({w, pos});
          state_next   = bpfa_pkg::S_FINISH;
        end else if (w == last_w) begin
          st_r_next  = bpfa_pkg::STAT_NOFREE;
          state_next = bpfa_pkg::S_FINISH;
        end else begin
          w_next     = w + AW'(1);
          state_next = bpfa_pkg::S_SCAN_RD;
        end
      end
      bpfa_pkg::S_FINISH: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_load        = 1'b1;
          clr_report_next = 1'b0;
          state_next      = bpfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bpfa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_c     <= (XW'(bpfa_pkg::TOTAL_RESET) > XW'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                                   : CW'(bpfa_pkg::TOTAL_RESET);
      used_c     <= '0;
      res_c      <= '0;
      sweep      <= '0;
      clr_report <= 1'b0;
    end else begin
      free_c     <= free_next;
      used_c     <= used_next;
      res_c      <= res_next;
      sweep      <= sweep_next;
      clr_report <= clr_report_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    end_f   <= end_f_next;
    w       <= w_next;
    wreg    <= wreg_next;
    cmd_r   <= cmd_r_next;
    st_r    <= st_r_next;
    frame_r <= frame_r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= bpfa_pkg::TOTAL_RESET;
      offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpfa_pkg::CFG_TOTAL:  total  <= cfg_data[16:0];
        bpfa_pkg::CFG_OFFSET: offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result register; a granted frame also gets its mapped address
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.status         <= st_r;
      out_ch.frame_number   <= 16'(frame_r);
      out_ch.mapped_address <= '0;
      if (cmd_r == bpfa_pkg::CMD_REQUEST && st_r == bpfa_pkg::STAT_OK) begin
        out_ch.mapped_address <= 49'({frame_r, {bpfa_pkg::FRAME_SH{1'b0}}}) + 49'(offset);
      end
      out_ch.free_pages     <= 17'(free_c);
      out_ch.used_pages     <= 17'(used_c);
      out_ch.reserved_pages <= 17'(res_c);
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ch.ready)
    else $error("command taken while previous one still in work");

  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == bpfa_pkg::STAT_NOFREE) |->
      (out_ch.frame_number == '0 && out_ch.mapped_address == '0))
    else $error("failed request reports a frame");

  a_counts_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(free_c) <= 32'(MAX_PAGES)) && (32'(used_c) <= 32'(MAX_PAGES))
      && (32'(res_c) <= 32'(MAX_PAGES)))
    else $error("page count beyond capacity");
`endif

endmodule

[test/tb_bitmap_page_frame_allocator_unit.sv]
// Self-checking testbench for the bitmap page frame allocator unit.
`timescale 1ns / 100ps

module tb_bitmap_page_frame_allocator_unit;

  localparam int   NPAGES   = 65536;
  localparam int   WD_LIMIT = 400000;
  localparam bpfa_pkg::cmd_t CMD_NOP6 = 3'd6;
  localparam bpfa_pkg::cmd_t CMD_NOP7 = 3'd7;

  typedef struct packed {
    bpfa_pkg::status_t status;
    logic [15:0] frame_number;
    logic [48:0] mapped_address;
    logic [16:0] free_pages;
    logic [16:0] used_pages;
    logic [16:0] reserved_pages;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  bpfa_pkg::cfg_idx_t cfg_index;
  logic [47:0] cfg_data;

  bpfa_in_if  in_ch();
  bpfa_out_if out_ch();

  bitmap_page_frame_allocator_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow allocator state
  bit          taken_bits [NPAGES];
  int unsigned free_cnt, used_cnt, resv_cnt;
  int unsigned total_reg;
  logic [47:0] offset_reg;

  alloc_result_t pending_results[$];
  int  errors;
  bit  idle_en;
  int  hold_req;
  int  hold_left;
  int  quiet_cycles;

  function automatic int unsigned eff_total();
    return (total_reg > NPAGES) ? NPAGES : total_reg;
  endfunction

  function automatic void clear_map();
    foreach (taken_bits[i]) taken_bits[i] = 1'b0;
    free_cnt = eff_total();
    used_cnt = 0;
    resv_cnt = 0;
  endfunction

  // Set a frame; count moves only on a real flip and within the saturation guard.
  function automatic void take_page(int unsigned f, bit to_resv);
    int unsigned dst;
    if (taken_bits[f]) return;
    taken_bits[f] = 1'b1;
    dst = to_resv ? resv_cnt : used_cnt;
    if (free_cnt < 1 || dst + 1 > eff_total()) return;
    free_cnt--;
    if (to_resv) resv_cnt++; else used_cnt++;
  endfunction

  function automatic void give_page(int unsigned f, bit from_resv);
    int unsigned src;
    if (!taken_bits[f]) return;
    taken_bits[f] = 1'b0;
    src = from_resv ? resv_cnt : used_cnt;
    if (src < 1 || free_cnt + 1 > eff_total()) return;
    free_cnt++;
    if (from_resv) resv_cnt--; else used_cnt--;
  endfunction

  function automatic alloc_result_t alloc_apply(bpfa_pkg::cmd_t c, logic [15:0] first,
                                                logic [16:0] n);
    alloc_result_t r;
    int unsigned t, f, i;
    bit found;
    t = eff_total();
    r = '0;
    r.status = bpfa_pkg::STAT_OK;
    if (c == bpfa_pkg::CMD_LOCK || c == bpfa_pkg::CMD_FREE ||
        c == bpfa_pkg::CMD_RESERVE || c == bpfa_pkg::CMD_RELEASE) begin
      for (i = 0; i < n; i++) begin
        f = first + i;
        if (f >= t) begin
          r.status = bpfa_pkg::STAT_RANGE;
        end else begin
          case (c)
            bpfa_pkg::CMD_LOCK:    take_page(f, 1'b0);
            bpfa_pkg::CMD_FREE:    give_page(f, 1'b0);
            bpfa_pkg::CMD_RESERVE: take_page(f, 1'b1);
            default:               give_page(f, 1'b1);
          endcase
        end
      end
    end else if (c == bpfa_pkg::CMD_REQUEST) begin
      found = 1'b0;
      for (i = 0; i < t; i++) begin
        if (!taken_bits[i]) begin
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        take_page(i, 1'b0);
        r.frame_number   = i[15:0];
        r.mapped_address = 49'(i) * 49'd4096 + 49'(offset_reg);
      end else begin
        r.status = bpfa_pkg::STAT_NOFREE;
      end
    end else if (c == bpfa_pkg::CMD_CLEAR) begin
      clear_map();
    end
    r.free_pages     = free_cnt[16:0];
    r.used_pages     = used_cnt[16:0];
    r.reserved_pages = resv_cnt[16:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Result side: random stalls, forced hold-off, and checking
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ch.status !== exp_r.status)
            report_mismatch($sformatf("status %0d exp %0d", out_ch.status, exp_r.status));
          if (out_ch.frame_number !== exp_r.frame_number)
            report_mismatch($sformatf("frame %0d exp %0d",
                                      out_ch.frame_number, exp_r.frame_number));
          if (out_ch.mapped_address !== exp_r.mapped_address)
            report_mismatch($sformatf("addr %h exp %h",
                                      out_ch.mapped_address, exp_r.mapped_address));
          if (out_ch.free_pages !== exp_r.free_pages)
            report_mismatch($sformatf("free %0d exp %0d",
                                      out_ch.free_pages, exp_r.free_pages));
          if (out_ch.used_pages !== exp_r.used_pages)
            report_mismatch($sformatf("used %0d exp %0d",
                                      out_ch.used_pages, exp_r.used_pages));
          if (out_ch.reserved_pages !== exp_r.reserved_pages)
            report_mismatch($sformatf("reserved %0d exp %0d",
                                      out_ch.reserved_pages, exp_r.reserved_pages));
        end
      end
      if (hold_req > 0) begin
        hold_left    <= hold_req;
        hold_req     = 0;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_en && $urandom_range(99) < 31);
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_cmd(bpfa_pkg::cmd_t c, logic [15:0] first, logic [16:0] n);
    while (idle_en && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.first_page <= first;
    in_ch.page_count <= n;
    pending_results.push_back(alloc_apply(c, first, n));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Wait until every result is in and the block takes commands again.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_cfg(bpfa_pkg::cfg_idx_t idx, logic [47:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == bpfa_pkg::CFG_TOTAL) total_reg = data[16:0];
    else offset_reg = data;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(bpfa_pkg::CMD_REQUEST, 16'd0, 17'd0);
    send_cmd(bpfa_pkg::CMD_LOCK, 16'd0, 17'd10);
    send_cmd(bpfa_pkg::CMD_LOCK, 16'd3, 17'd4);          // already taken, no count change
    send_cmd(bpfa_pkg::CMD_REQUEST, 16'hffff, 17'h1ffff);
    send_cmd(bpfa_pkg::CMD_FREE, 16'd2, 17'd0);          // empty run
    send_cmd(bpfa_pkg::CMD_FREE, 16'd2, 17'd3);
    send_cmd(bpfa_pkg::CMD_FREE, 16'd2, 17'd3);          // already clear
    send_cmd(bpfa_pkg::CMD_REQUEST, 16'd0, 17'd0);
    send_cmd(bpfa_pkg::CMD_RESERVE, 16'd65530, 17'd10);  // runs past the top
    send_cmd(bpfa_pkg::CMD_RESERVE, 16'd65535, 17'd1);
    send_cmd(bpfa_pkg::CMD_RELEASE, 16'd65530, 17'd3);
    send_cmd(bpfa_pkg::CMD_RELEASE, 16'd65535, 17'd1);
    send_cmd(CMD_NOP6, 16'd7, 17'd7);
    send_cmd(CMD_NOP7, 16'd9, 17'd9);
    send_cmd(bpfa_pkg::CMD_LOCK, 16'd0, 17'd65536);      // whole map
    send_cmd(bpfa_pkg::CMD_REQUEST, 16'd0, 17'd0);       // nothing free
    send_cmd(bpfa_pkg::CMD_FREE, 16'd40000, 17'd1);
    send_cmd(bpfa_pkg::CMD_CLEAR, 16'd0, 17'd0);
    write_cfg(bpfa_pkg::CFG_OFFSET, 48'hffff_ffff_ffff);
    send_cmd(bpfa_pkg::CMD_LOCK, 16'd0, 17'd4095);
    send_cmd(bpfa_pkg::CMD_REQUEST, 16'd0, 17'd0);       // top address bit
    send_cmd(bpfa_pkg::CMD_RESERVE, 16'd0, 17'd4097);
    send_cmd(bpfa_pkg::CMD_CLEAR, 16'd0, 17'd0);
  endtask

  // Lowered total without clear: counts saturate against the new total.
  task automatic test_saturation();
    write_cfg(bpfa_pkg::CFG_TOTAL, 17'd20);
    send_cmd(bpfa_pkg::CMD_LOCK, 16'd0, 17'd30);
    send_cmd(bpfa_pkg::CMD_FREE, 16'd5, 17'd5);
    send_cmd(bpfa_pkg::CMD_REQUEST, 16'd0, 17'd0);
    send_cmd(bpfa_pkg::CMD_CLEAR, 16'd0, 17'd0);
    write_cfg(bpfa_pkg::CFG_TOTAL, 17'd1);
    send_cmd(bpfa_pkg::CMD_REQUEST, 16'd0, 17'd0);
    send_cmd(bpfa_pkg::CMD_REQUEST, 16'd0, 17'd0);
    send_cmd(bpfa_pkg::CMD_RESERVE, 16'd0, 17'd2);
    send_cmd(bpfa_pkg::CMD_FREE, 16'd0, 17'd1);
    send_cmd(bpfa_pkg::CMD_CLEAR, 16'd0, 17'd0);
  endtask

  task automatic send_random(int n_items);
    int unsigned t, pick, big_left;
    bpfa_pkg::cmd_t c;
    logic [15:0] first;
    logic [16:0] n;
    big_left = 1;
    for (int k = 0; k < n_items; k++) begin
      t = eff_total();
      pick = $urandom_range(99);
      if (pick < 22)      c = bpfa_pkg::CMD_LOCK;
      else if (pick < 40) c = bpfa_pkg::CMD_FREE;
      else if (pick < 58) c = bpfa_pkg::CMD_RESERVE;
      else if (pick < 74) c = bpfa_pkg::CMD_RELEASE;
      else if (pick < 96) c = bpfa_pkg::CMD_REQUEST;
      else if (pick < 98) c = bpfa_pkg::CMD_CLEAR;
      else                c = ($urandom_range(1)) ? CMD_NOP6 : CMD_NOP7;
      if ($urandom_range(9) < 7) first = 16'($urandom_range(t > 64 ? 63 : t - 1));
      else if ($urandom_range(1)) first = 16'($urandom_range(t - 1));
      else first = 16'($urandom);
      if (big_left > 0 && $urandom_range(199) == 0) begin
        n = 17'($urandom_range(65536, 4096));
        big_left--;
      end else begin
        n = 17'($urandom_range(48));
      end
      send_cmd(c, first, n);
    end
  endtask

  task automatic test_random_phases();
    write_cfg(bpfa_pkg::CFG_TOTAL, 17'd65536);
    write_cfg(bpfa_pkg::CFG_OFFSET, 48'($urandom) << 16 | 48'($urandom_range(65535)));
    send_cmd(bpfa_pkg::CMD_CLEAR, 16'd0, 17'd0);
    send_random(200);
    write_cfg(bpfa_pkg::CFG_TOTAL, 17'd100);
    write_cfg(bpfa_pkg::CFG_OFFSET, 48'd0);
    send_cmd(bpfa_pkg::CMD_CLEAR, 16'd0, 17'd0);
    send_random(200);
    write_cfg(bpfa_pkg::CFG_TOTAL, 17'($urandom_range(65536, 1)));
    send_random(200);
    write_cfg(bpfa_pkg::CFG_TOTAL, 17'd1);
    send_cmd(bpfa_pkg::CMD_CLEAR, 16'd0, 17'd0);
    send_random(100);
  endtask

  task automatic test_backpressure();
    write_cfg(bpfa_pkg::CFG_TOTAL, 17'd4096);
    write_cfg(bpfa_pkg::CFG_OFFSET, 48'h1234_5678_9abc);
    send_cmd(bpfa_pkg::CMD_CLEAR, 16'd0, 17'd0);
    hold_req = 400;
    send_random(40);
    drain();  // sender waits for every result
    idle_en = 1'b0;
    send_random(150);
    idle_en = 1'b1;
    send_random(100);
  endtask

  initial begin
    errors      = 0;
    idle_en     = 1'b1;
    hold_req    = 0;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= bpfa_pkg::CFG_TOTAL;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= bpfa_pkg::CMD_LOCK;
    in_ch.first_page <= '0;
    in_ch.page_count <= '0;
    total_reg   = bpfa_pkg::TOTAL_RESET;
    offset_reg  = '0;
    clear_map();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);  // clearing sweep after reset

    test_directed();
    test_saturation();
    test_random_phases();
    test_backpressure();

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
